// ===== design/ema_hysteresis_channel_filter_unit_macros.svh =====
// Assertion helpers for the filter top-level design file.
`ifndef EMA_HYSTERESIS_CHANNEL_FILTER_UNIT_MACROS_SVH
`define EMA_HYSTERESIS_CHANNEL_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehcf same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EHCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehcf next-cycle check failed");

`endif

// ===== design/ehcf_pkg.sv =====
package ehcf_pkg;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 12;
    localparam int ACC_W    = 18;
    localparam int THR_W    = 8;
    localparam int STR_W    = 2;
    localparam int SHIFT_W  = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FILTER_STRENGTH      = 1'b0,
        CFG_HYSTERESIS_THRESHOLD = 1'b1
    } t_cfg_idx;

    // Filter strength codes.
    localparam logic [STR_W-1:0] STR_OFF    = 2'd0;
    localparam logic [STR_W-1:0] STR_LIGHT  = 2'd1;
    localparam logic [STR_W-1:0] STR_MEDIUM = 2'd2;
    localparam logic [STR_W-1:0] STR_HEAVY  = 2'd3;

    localparam logic [STR_W-1:0] STRENGTH_RESET  = STR_MEDIUM;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } t_ehcf_in;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel_out;
        logic [SAMPLE_W-1:0] filtered_value;
    } t_ehcf_out;

    // One channel's stored state.
    typedef struct packed {
        logic [ACC_W-1:0]    acc;
        logic [SAMPLE_W-1:0] held;
    } t_ehcf_entry;

    // Strength code to EMA shift amount.
    function automatic logic [SHIFT_W-1:0] strength_to_shift(input logic [STR_W-1:0] str);
        logic [SHIFT_W-1:0] sh;
        unique case (str)
            STR_OFF:    sh = 3'd0;
            STR_LIGHT:  sh = 3'd3;
            STR_MEDIUM: sh = 3'd5;
            STR_HEAVY:  sh = 3'd6;
            default:    sh = 3'd5;
        endcase
        return sh;
    endfunction

endpackage

// ===== design/ehcf_store.sv =====
module ehcf_store
    import ehcf_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int IDX_W        = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_ehcf_entry      o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_ehcf_entry      i_wr_data,
    input  logic [IDX_W-1:0] i_pr_idx,
    output logic             o_primed
);

    t_ehcf_entry r_mem [NUM_CHANNELS];
    t_ehcf_entry r_rd_data;
    logic [NUM_CHANNELS-1:0] r_primed;

    // State memory with one registered read port and one write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Primed flags are cleared by reset and set by the first write of a channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= '0;
        end else if (i_wr_en) begin
            r_primed[i_wr_idx] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_primed  = r_primed[i_pr_idx];

endmodule

// ===== design/ehcf_update.sv =====
module ehcf_update
    import ehcf_pkg::*;
(
    input  logic [STR_W-1:0]    i_strength,
    input  logic [THR_W-1:0]    i_threshold,
    input  logic                i_primed,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_ehcf_entry         i_entry,
    output t_ehcf_entry         o_entry
);

    logic [SHIFT_W-1:0]  shift;
    logic [SHIFT_W-1:0]  seed_shift;
    logic [ACC_W-1:0]    sample_x;
    logic [ACC_W-1:0]    acc_new;
    logic [ACC_W-1:0]    ema_full;
    logic [SAMPLE_W-1:0] ema;
    logic [SAMPLE_W-1:0] delta;
    logic                take;

    assign shift      = strength_to_shift(i_strength);
    assign seed_shift = (shift == '0) ? SHIFT_W'(1) : shift;
    assign sample_x   = ACC_W'(i_sample);

    // Accumulator: seed first sample; off: sample << 1; else leaky integrate.
    always_comb begin
        if (!i_primed) begin
            acc_new = sample_x << seed_shift;
        end else if (shift == '0) begin
            acc_new = sample_x << 1;
        end else begin
            acc_new = i_entry.acc - (i_entry.acc >> shift) + sample_x;
        end
    end

    // Scaled-down average, saturated to the sample range.
    assign ema_full = acc_new >> seed_shift;
    assign ema      = (|ema_full[ACC_W-1:SAMPLE_W]) ? '1 : ema_full[SAMPLE_W-1:0];

    // Hysteresis on the held output.
    assign delta = (ema >= i_entry.held) ? (ema - i_entry.held) : (i_entry.held - ema);
    assign take  = (delta > SAMPLE_W'(i_threshold)) || (shift == '0);

    always_comb begin
        o_entry.acc = acc_new;
        if (!i_primed) begin
            o_entry.held = i_sample;
        end else if (take) begin
            o_entry.held = ema;
        end else begin
            o_entry.held = i_entry.held;
        end
    end

endmodule

// ===== design/ema_hysteresis_channel_filter_unit.sv =====
// Channel   | Signals                                   | Moves
// ----------+-------------------------------------------+------------------------------
// input     | i_in_valid / o_in_ready / i_in_data       | channel, sample
// output    | o_out_valid / i_out_ready / o_out_data    | channel_out, filtered_value
// config    | i_cfg_we / i_cfg_idx / i_cfg_wdata        | strength, hysteresis threshold
//
// One transaction per cycle is sustained while the output is not stalled; the memory read and
// the update stage register at the edge that takes the input, then update and write-back
// into the output register happen when the update stage advances.
// The rate is set by the single read-modify-write on the per-channel state memory;
// a same-channel follower gets the just-written entry through a forwarding register.
// Reset clears the primed flags; the state memory needs no clearing pass.
// A stalled output holds the update stage, and input ready drops only when both are full.
`include "ema_hysteresis_channel_filter_unit_macros.svh"

module ema_hysteresis_channel_filter_unit
    import ehcf_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_ehcf_in         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_ehcf_out        o_out_data,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [THR_W-1:0] i_cfg_wdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    // One bit above the wider of the two so that NUM_CHANNELS itself fits.
    localparam int CHX_W = ((IDX_W > CHAN_W) ? IDX_W : CHAN_W) + 1;

    logic [STR_W-1:0] r_strength;
    logic [THR_W-1:0] r_threshold;

    logic        r_s1_valid;
    t_ehcf_in    r_s1_data;
    logic        r_out_valid;
    t_ehcf_out   r_out_data;

    logic             r_fw_valid;
    logic [IDX_W-1:0] r_fw_idx;
    t_ehcf_entry      r_fw_entry;

    logic             accept;
    logic             advance;
    logic             wb_en;
    logic [CHX_W-1:0] in_ch_x;
    logic [CHX_W-1:0] s1_ch_x;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] s1_idx;
    logic             s1_in_range;
    logic             fw_hit;
    t_ehcf_entry      rd_entry;
    t_ehcf_entry      cur_entry;
    t_ehcf_entry      new_entry;
    logic             primed;
    logic             out_oor;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength  <= STRENGTH_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_STRENGTH:      r_strength  <= i_cfg_wdata[STR_W-1:0];
                CFG_HYSTERESIS_THRESHOLD: r_threshold <= i_cfg_wdata;
                default:                  r_threshold <= r_threshold;
            endcase
        end
    end

    // Handshake and channel index decode.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    assign in_ch_x     = CHX_W'(i_in_data.channel);
    assign s1_ch_x     = CHX_W'(r_s1_data.channel);
    assign in_idx      = in_ch_x[IDX_W-1:0];
    assign s1_idx      = s1_ch_x[IDX_W-1:0];
    assign s1_in_range = (s1_ch_x < CHX_W'(NUM_CHANNELS));
    assign wb_en       = r_s1_valid && advance && s1_in_range;

    ehcf_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_idx  (in_idx),
        .o_rd_data (rd_entry),
        .i_wr_en   (wb_en),
        .i_wr_idx  (s1_idx),
        .i_wr_data (new_entry),
        .i_pr_idx  (s1_idx),
        .o_primed  (primed)
    );

    // The last write-back wins over a read that raced with it.
    assign fw_hit    = r_fw_valid && (r_fw_idx == s1_idx);
    assign cur_entry = fw_hit ? r_fw_entry : rd_entry;

    ehcf_update u_update (
        .i_strength  (r_strength),
        .i_threshold (r_threshold),
        .i_primed    (primed),
        .i_sample    (r_s1_data.sample),
        .i_entry     (cur_entry),
        .o_entry     (new_entry)
    );

    // Update stage holding the item while its memory read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_data <= i_in_data;
        end
    end

    // Forwarding copy of the most recent write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (wb_en) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            r_fw_idx   <= s1_idx;
            r_fw_entry <= new_entry;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_data.channel_out    <= r_s1_data.channel;
            r_out_data.filtered_value <= s1_in_range ? new_entry.held : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks.
    assign out_oor = (CHX_W'(r_out_data.channel_out) >= CHX_W'(NUM_CHANNELS));

    `EHCF_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, accept, r_s1_valid)
    `EHCF_ASSERT_NOW(a_ready_low_only_when_full, i_clk, i_rst_n, !o_in_ready,
        r_s1_valid && r_out_valid && !i_out_ready)
    `EHCF_ASSERT_NOW(a_oor_result_zero, i_clk, i_rst_n, r_out_valid && out_oor,
        r_out_data.filtered_value == '0)
    `EHCF_ASSERT_NEXT(a_writeback_forwards, i_clk, i_rst_n, wb_en,
        r_fw_valid && (r_fw_idx == $past(s1_idx)))

endmodule

// ===== tb/sv/ema_hysteresis_channel_filter_unit_tb.sv =====
`timescale 1ns / 1ps

import ehcf_pkg::*;

// Tracks per-channel filter state and the results still owed by the block.
class channel_filter_tracker;
    localparam int CHANNELS = 8;

    logic [ACC_W-1:0]    acc_mem  [CHANNELS];
    logic [SAMPLE_W-1:0] held_mem [CHANNELS];
    bit                  primed   [CHANNELS];
    logic [STR_W-1:0]    strength;
    logic [THR_W-1:0]    threshold;
    t_ehcf_out           held_due_q[$];
    int                  errors;
    int                  checked;

    function new();
        foreach (primed[i]) primed[i] = 1'b0;
        strength  = STRENGTH_RESET;
        threshold = THRESHOLD_RESET;
        errors    = 0;
        checked   = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [THR_W-1:0] value);
        if (idx == CFG_FILTER_STRENGTH)
            strength = value[STR_W-1:0];
        else
            threshold = value;
    endfunction

    // Works out the held value that an accepted sample transaction produces.
    function void note_sample(t_ehcf_in item);
        int unsigned shamt;
        int unsigned acc_now;
        int unsigned ema;
        int unsigned diff;
        int unsigned held;
        t_ehcf_out   res;
        case (strength)
            STR_OFF:   shamt = 0;
            STR_LIGHT: shamt = 3;
            STR_HEAVY: shamt = 6;
            default:   shamt = 5;
        endcase
        res.channel_out = item.channel;
        if (int'(item.channel) < CHANNELS) begin
            if (!primed[item.channel]) begin
                // A fresh channel is seeded directly from its first sample.
                acc_now = int'(item.sample) << ((shamt != 0) ? shamt : 1);
                acc_mem[item.channel]  = acc_now[ACC_W-1:0];
                held_mem[item.channel] = item.sample;
                primed[item.channel]   = 1'b1;
            end else begin
                acc_now = 32'(acc_mem[item.channel]);
                if (shamt == 0)
                    acc_now = int'(item.sample) << 1;
                else
                    acc_now = acc_now - (acc_now >> shamt) + int'(item.sample);
                acc_now = acc_now & ((1 << ACC_W) - 1);
                acc_mem[item.channel] = acc_now[ACC_W-1:0];
                ema = acc_now >> ((shamt != 0) ? shamt : 1);
                // The average can overflow 12 bits after the strength is lowered.
                if (ema > 4095)
                    ema = 4095;
                held = 32'(held_mem[item.channel]);
                diff = (ema >= held) ? (ema - held) : (held - ema);
                if (diff > int'(threshold) || shamt == 0)
                    held_mem[item.channel] = ema[SAMPLE_W-1:0];
            end
            res.filtered_value = held_mem[item.channel];
        end else begin
            res.filtered_value = '0;
        end
        held_due_q.push_back(res);
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_output(t_ehcf_out got);
        t_ehcf_out want;
        checked++;
        if (held_due_q.size() == 0) begin
            $error("unexpected result: channel_out %0d filtered_value %0d",
                   got.channel_out, got.filtered_value);
            errors++;
            return;
        end
        want = held_due_q.pop_front();
        if (got.channel_out !== want.channel_out) begin
            $error("channel_out: expected %0d, actual %0d", want.channel_out, got.channel_out);
            errors++;
        end
        if (got.filtered_value !== want.filtered_value) begin
            $error("filtered_value: expected %0d, actual %0d",
                   want.filtered_value, got.filtered_value);
            errors++;
        end
    endfunction

    function int pending();
        return held_due_q.size();
    endfunction
endclass

module ema_hysteresis_channel_filter_unit_tb;
    localparam int CHANNELS    = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_AFTER = 300;
    localparam int STALL_LEN   = 80;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    t_ehcf_in         in_data     = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    t_ehcf_out        out_data;
    logic             cfg_we      = 1'b0;
    t_cfg_idx         cfg_idx     = CFG_FILTER_STRENGTH;
    logic [THR_W-1:0] cfg_wdata   = '0;

    channel_filter_tracker tracker = new();
    bit                    idle_on = 1'b1;
    bit                    stall_done = 1'b0;
    int unsigned           cycle_cnt = 0;

    ema_hysteresis_channel_filter_unit #(
        .NUM_CHANNELS(CHANNELS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** ema_hysteresis_channel_filter_unit: FAILED **");
            $finish;
        end
    end

    // Offers one sample transaction and returns at the edge that accepts it.
    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        t_ehcf_in item;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        item.channel = ch;
        item.sample  = smp;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        tracker.note_sample(item);
    endtask

    // Waits until every result is back, then lets the pipeline empty.
    task automatic settle();
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the strength register, then the threshold register.
    task automatic program_filter(input logic [STR_W-1:0] str, input logic [THR_W-1:0] thr);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_FILTER_STRENGTH;
        cfg_wdata <= THR_W'(str);
        @(posedge i_clk);
        tracker.write_reg(CFG_FILTER_STRENGTH, THR_W'(str));
        cfg_idx   <= CFG_HYSTERESIS_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge i_clk);
        tracker.write_reg(CFG_HYSTERESIS_THRESHOLD, thr);
        cfg_we <= 1'b0;
    endtask

    // Result side: random ready gaps plus one long hold-off.
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!stall_done && tracker.checked >= STALL_AFTER) begin
                gap        = STALL_LEN;
                stall_done = 1'b1;
            end else begin
                gap = idle_on ? $urandom_range(0, 6) : 0;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            tracker.check_output(out_data);
        end
    end

    // Stimulus: directed phases first, then random phases.
    initial begin
        logic [SAMPLE_W-1:0] base [CHANNELS];
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] smp;
        logic [STR_W-1:0]    str;
        logic [THR_W-1:0]    thr;
        int                  pick;
        int                  v;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first samples of six channels, then primed updates.
        send_sample(3'd0, 12'd0);
        send_sample(3'd1, 12'hFFF);
        send_sample(3'd2, 12'd2048);
        send_sample(3'd3, 12'd1);
        send_sample(3'd4, 12'hAAA);
        send_sample(3'd5, 12'h555);
        send_sample(3'd0, 12'hFFF);
        send_sample(3'd1, 12'd0);
        in_valid <= 1'b0;
        settle();

        // Heavy filter with no hysteresis: channel 7 is seeded near full scale.
        program_filter(STR_HEAVY, 8'd0);
        send_sample(3'd7, 12'hFFF);
        send_sample(3'd7, 12'd0);
        send_sample(3'd7, 12'd0);
        send_sample(3'd2, 12'hFFF);
        in_valid <= 1'b0;
        settle();

        // Filter off: the held value follows every sample, and seeding uses one shift.
        program_filter(STR_OFF, 8'd255);
        send_sample(3'd6, 12'd2048);
        send_sample(3'd6, 12'd1);
        send_sample(3'd3, 12'hFFF);
        in_valid <= 1'b0;
        settle();

        // Lowering the strength with a large accumulator drives the average to saturation.
        program_filter(STR_LIGHT, 8'd0);
        send_sample(3'd7, 12'd0);
        send_sample(3'd7, 12'd0);
        send_sample(3'd4, 12'hFFF);
        in_valid <= 1'b0;
        settle();

        // Medium filter with the widest hysteresis band.
        program_filter(STR_MEDIUM, 8'd255);
        send_sample(3'd5, 12'hFFF);
        send_sample(3'd0, 12'd0);
        in_valid <= 1'b0;
        settle();

        foreach (base[i]) base[i] = SAMPLE_W'($urandom_range(0, 4095));

        // Random phases; two of them run with no idling on either side.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin str = STR_OFF;    thr = 8'd0;   end
                1: begin str = STR_HEAVY;  thr = 8'd255; end
                2: begin str = STR_LIGHT;  thr = 8'd0;   end
                3: begin str = STR_MEDIUM; thr = 8'd7;   end
                4: begin str = STR_HEAVY;  thr = 8'd1;   end
                default: begin
                    str = STR_W'($urandom_range(0, 3));
                    thr = THR_W'($urandom_range(0, 255));
                end
            endcase
            settle();
            program_filter(str, thr);
            idle_on = (p != 2 && p != 5);
            repeat (175) begin
                ch   = CHAN_W'($urandom_range(0, CHANNELS - 1));
                pick = $urandom_range(0, 9);
                if ($urandom_range(0, 19) == 0)
                    base[ch] = SAMPLE_W'($urandom_range(0, 4095));
                if (pick == 0) begin
                    smp = 12'd0;
                end else if (pick == 1) begin
                    smp = 12'hFFF;
                end else if (pick <= 4) begin
                    smp = SAMPLE_W'($urandom_range(0, 4095));
                end else begin
                    // Small noise around a per-channel level exercises the hysteresis band.
                    v = int'(base[ch]) + int'($urandom_range(0, 16)) - 8;
                    if (v < 0) v = 0;
                    if (v > 4095) v = 4095;
                    smp = v[SAMPLE_W-1:0];
                end
                send_sample(ch, smp);
            end
            in_valid <= 1'b0;
        end
        idle_on = 1'b1;

        settle();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("** ema_hysteresis_channel_filter_unit: PASSED **");
        end else begin
            $display("** ema_hysteresis_channel_filter_unit: FAILED **");
        end
        $finish;
    end
endmodule
